>>> rtl/core/sptpd_pkg.sv
package sptpd_pkg;

    // Character codes the parser reacts to
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TAB   = 8'd9;
    localparam logic [7:0] CHAR_VT    = 8'd11;
    localparam logic [7:0] CHAR_FF    = 8'd12;
    localparam logic [7:0] CHAR_PLUS  = 8'd43;
    localparam logic [7:0] CHAR_MINUS = 8'd45;
    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_NINE  = 8'd57;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int MAG_W     = 7;
    localparam int DUTY_W    = 16;
    localparam int PCT_W     = 7;
    localparam int OUT_W     = 1 + DUTY_W + PCT_W;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Magnitude limits
    localparam logic [MAG_W-1:0] MAG_SAT = 7'd101;
    localparam logic [MAG_W-1:0] PCT_MAX = 7'd100;

    // Register map
    localparam logic [APB_AW-1:0] ADDR_PWM_PERIOD = 3'd0;

    // Reset values
    localparam logic [DUTY_W-1:0] PERIOD_RESET = 16'd999;
    localparam logic [DUTY_W-1:0] DUTY_RESET   = 16'd500;

    // Divide by 100: floor(x/100) = (x * RECIP_100) >> RECIP_SHIFT for x < 2**PROD_W
    localparam int PROD_W      = MAG_W + DUTY_W;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

endpackage

>>> rtl/core/serial_percent_to_pwm_duty.sv
// Channel   | Dir | Handshake          | Payload
// ----------+-----+--------------------+--------------------------------------------
// s_*       | in  | s_tvalid/s_tready  | s_tdata[7:0] = byte_in
// m_*       | out | m_tvalid/m_tready  | m_tdata = range_error, duty_out, percent_out
// APB       | in  | psel/penable/pready| pwm_period at byte address 0
//
// One byte is taken every cycle while the output side keeps up.
// A non-empty line's end gives its result via stage A (percent-times-period product),
// then the output stage, which does the multiply-by-reciprocal divide by 100.
// Reset clears the line parser, sets pwm_period to 999 and the duty to 500.
// A stalled result holds both pipeline stages; s_tready drops only when both are full.
module serial_percent_to_pwm_duty #(
    parameter int BUFFER_SIZE = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // byte_in [7:0]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sptpd_pkg::BYTE_W-1:0]      s_tdata,
    // range_error [0], duty_out [16:1], percent_out [23:17]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sptpd_pkg::OUT_W-1:0]       m_tdata,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sptpd_pkg::APB_AW-1:0]      paddr,
    input  logic [sptpd_pkg::APB_DW-1:0]      pwdata,
    output logic [sptpd_pkg::APB_DW-1:0]      prdata,
    output logic                              pready
);
    import sptpd_pkg::*;

    localparam int KEEP_W = (BUFFER_SIZE > 2) ? $clog2(BUFFER_SIZE) : 1;
    localparam logic [KEEP_W-1:0] KEEP_MAX = KEEP_W'(BUFFER_SIZE - 1);

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_DONE   = 2'd3
    } phase_t;

    logic [DUTY_W-1:0] period_reg;
    logic [KEEP_W-1:0] kept_reg, kept_next;
    phase_t            phase_reg, phase_next;
    logic              neg_reg, neg_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;

    logic              a_valid_reg;
    logic              a_err_reg;
    logic [PCT_W-1:0]  a_pct_reg;
    logic [PROD_W-1:0] a_prod_reg;

    logic              out_valid_reg;
    logic              out_err_reg;
    logic [PCT_W-1:0]  out_pct_reg;
    logic [DUTY_W-1:0] duty_reg, duty_next;

    logic              in_take;
    logic              out_free;
    logic              is_eol;
    logic              is_digit;
    logic              is_space;
    logic              line_result;
    logic              line_err;
    logic [9:0]        mag_grow;
    logic [PROD_W-1:0] prod_next;
    logic [PROD_W+RECIP_W-1:0] q_full;
    logic [DUTY_W-1:0] duty_calc;
    logic              cfg_write;

    // Handshake: stage A may move on whenever the output slot is free
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = !a_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    // Classify the incoming byte
    assign is_eol   = (s_tdata == CHAR_CR) || (s_tdata == CHAR_LF);
    assign is_digit = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign is_space = (s_tdata == CHAR_SPACE) || (s_tdata == CHAR_TAB)
                   || (s_tdata == CHAR_VT) || (s_tdata == CHAR_FF);
    assign line_result = is_eol && (kept_reg != '0);
    assign line_err    = (mag_reg > PCT_MAX) || (neg_reg && (mag_reg != '0));

    // Accumulate one decimal digit, saturating at 101
    assign mag_grow = 10'(mag_reg) * 10'd10 + 10'(s_tdata - CHAR_ZERO);

    // Line parser next state
    always_comb
    begin
        kept_next  = kept_reg;
        phase_next = phase_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        if (is_eol)
        begin
            kept_next  = '0;
            phase_next = PH_SKIP;
            neg_next   = 1'b0;
            mag_next   = '0;
        end
        else if (kept_reg < KEEP_MAX)
        begin
            kept_next = kept_reg + 1'b1;
            if (phase_reg == PH_SKIP && is_space)
            begin
                phase_next = PH_SKIP;
            end
            else if (phase_reg == PH_SKIP
                     && (s_tdata == CHAR_PLUS || s_tdata == CHAR_MINUS))
            begin
                neg_next   = (s_tdata == CHAR_MINUS);
                phase_next = PH_SIGN;
            end
            else if (phase_reg != PH_DONE)
            begin
                if (is_digit)
                begin
                    mag_next   = (mag_grow > 10'(MAG_SAT)) ? MAG_SAT : mag_grow[MAG_W-1:0];
                    phase_next = PH_DIGITS;
                end
                else
                begin
                    phase_next = PH_DONE;
                end
            end
        end
    end

    // Percent times period, taken from the held magnitude
    assign prod_next = PROD_W'(mag_reg) * PROD_W'(period_reg);

    // Divide the product by 100 through the reciprocal
    assign q_full    = (PROD_W+RECIP_W)'(a_prod_reg) * (PROD_W+RECIP_W)'(RECIP_100);
    assign duty_calc = q_full[RECIP_SHIFT +: DUTY_W];
    assign duty_next = a_err_reg ? duty_reg : duty_calc;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kept_reg  <= '0;
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        else if (in_take)
        begin
            kept_reg  <= kept_next;
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            mag_reg   <= mag_next;
        end
    end

    // Stage A: hold the line verdict and the product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            a_valid_reg <= in_take && line_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && line_result)
        begin
            a_err_reg  <= line_err;
            a_pct_reg  <= line_err ? '0 : mag_reg;
            a_prod_reg <= prod_next;
        end
    end

    // Output stage: commit the duty and present the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            duty_reg      <= DUTY_RESET;
        end
        else if (out_free)
        begin
            out_valid_reg <= a_valid_reg;
            if (a_valid_reg)
            begin
                duty_reg <= duty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && a_valid_reg)
        begin
            out_err_reg <= a_err_reg;
            out_pct_reg <= a_pct_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pct_reg, duty_reg, out_err_reg};

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[APB_AW-1] == ADDR_PWM_PERIOD[APB_AW-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            period_reg <= pwdata[DUTY_W-1:0];
        end
    end

    assign prdata = (paddr[APB_AW-1] == ADDR_PWM_PERIOD[APB_AW-1])
                  ? APB_DW'(period_reg) : '0;

    // Checks
    a_err_no_pct: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[0] |-> m_tdata[OUT_W-1 -: PCT_W] == '0)
        else $error("range error result carries a nonzero percent");

    a_kept_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kept_reg <= KEEP_MAX)
        else $error("kept count ran past the line buffer");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && is_eol |=> kept_reg == '0 && mag_reg == '0 && phase_reg == PH_SKIP)
        else $error("line state not cleared after line end");

    a_result_issued: assert property (@(posedge clk) disable iff (!rst_n)
        in_take && line_result |=> a_valid_reg)
        else $error("non-empty line end did not issue a result");

endmodule
